// ===== src/rlps_pkg.sv =====
// shared types, codes and constants of the rgb led pulse width serializer
package rlps_pkg;

  localparam int unsigned REG_W      = 10;
  localparam int unsigned NUM_REGS   = 6;
  localparam int unsigned REG_IDX_W  = $clog2(NUM_REGS);
  localparam int unsigned NBITS      = 24;
  localparam int unsigned BITS_W     = $clog2(NBITS + 1);
  localparam int unsigned TICK_COUNT_WIDTH_DEF = 10;

  // register indexes
  localparam logic [REG_IDX_W-1:0] REG_ONE_HIGH  = REG_IDX_W'(0);
  localparam logic [REG_IDX_W-1:0] REG_ONE_LOW   = REG_IDX_W'(1);
  localparam logic [REG_IDX_W-1:0] REG_ZERO_HIGH = REG_IDX_W'(2);
  localparam logic [REG_IDX_W-1:0] REG_ZERO_LOW  = REG_IDX_W'(3);
  localparam logic [REG_IDX_W-1:0] REG_RST_HIGH  = REG_IDX_W'(4);
  localparam logic [REG_IDX_W-1:0] REG_RST_LOW   = REG_IDX_W'(5);

  localparam logic [REG_W-1:0] REG_RESET [NUM_REGS] = '{
    REG_W'(17), REG_W'(5), REG_W'(5), REG_W'(17), REG_W'(8), REG_W'(22)
  };

  // operation codes; the fourth code acts as a plain tick
  localparam logic [1:0] OP_TICK  = 2'd0;
  localparam logic [1:0] OP_PIXEL = 2'd1;
  localparam logic [1:0] OP_RESET = 2'd2;

  typedef enum logic [2:0] {
    PH_IDLE     = 3'd0,
    PH_BIT_HIGH = 3'd1,
    PH_BIT_LOW  = 3'd2,
    PH_RST_HIGH = 3'd3,
    PH_RST_LOW  = 3'd4
  } phase_e;

  typedef struct packed {
    logic [1:0] operation;
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
  } in_item_t;

  typedef struct packed {
    logic line_level;
    logic busy_res;
    logic refused;
  } out_item_t;

endpackage

// ===== src/rlps_stream_if.sv =====
// valid/ready stream channel carrying one item per handshake
interface rlps_stream_if #(
  parameter type payload_t = logic
);
  logic     valid;
  logic     ready;
  payload_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

// ===== src/rgb_led_pulse_width_serializer.sv =====
// serial rgb led line encoder with pulse width coded bits, one item per tick
// result: the result of an item is registered and presented in the cycle after it is accepted
// throughput: one item per cycle while the result is taken; the phase counter, bit shifter and output
//   register all update in a single pass from the accepted item
// reset: timing registers return to their defaults, the encoder goes idle
//   and the line idles low until the first reset pulse; no clearing pass
module rgb_led_pulse_width_serializer #(
  parameter int unsigned TICK_COUNT_WIDTH = rlps_pkg::TICK_COUNT_WIDTH_DEF
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            cfg_we_i,
  input  logic [rlps_pkg::REG_IDX_W-1:0]  cfg_idx_i,
  input  logic [rlps_pkg::REG_W-1:0]      cfg_wdata_i,
  rlps_stream_if.sink                     item_i,
  rlps_stream_if.source                   result_o
);
  import rlps_pkg::*;

  localparam int unsigned TW = TICK_COUNT_WIDTH;

  // timing registers, one per pulse phase duration
  logic [REG_W-1:0] cfg_q [NUM_REGS];

  // encoder state
  phase_e              phase_q, phase_d;
  logic [TW-1:0]       count_q, count_d;
  logic [NBITS-1:0]    shift_q, shift_d;
  logic [BITS_W-1:0]   bits_q,  bits_d;
  logic                idle_lvl_q, idle_lvl_d;

  // state after the command of the current item is applied
  phase_e              ph_s;
  logic [TW-1:0]       cnt_s;
  logic [NBITS-1:0]    shf_s;
  logic [BITS_W-1:0]   bits_s;

  // output register
  logic                out_valid_q;
  out_item_t           out_data_q;
  out_item_t           res_c;

  in_item_t            in_c;
  logic                in_fire;
  logic                is_cmd;

  // a zero duration lasts one tick
  function automatic logic [TW-1:0] ticks_of(input logic [REG_W-1:0] v);
    logic [TW-1:0] t;
    t = TW'(v);
    return (t == '0) ? TW'(1) : t;
  endfunction

  assign in_c    = item_i.data;
  // the output register frees up whenever the result is taken
  assign item_i.ready = !out_valid_q || result_o.ready;
  assign in_fire = item_i.valid && item_i.ready;
  assign is_cmd  = (in_c.operation == OP_PIXEL) || (in_c.operation == OP_RESET);

  assign result_o.valid = out_valid_q;
  assign result_o.data  = out_data_q;

  // command load, only taken while idle
  always_comb begin
    ph_s   = phase_q;
    cnt_s  = count_q;
    shf_s  = shift_q;
    bits_s = bits_q;
    if (phase_q == PH_IDLE) begin
      if (in_c.operation == OP_PIXEL) begin
        shf_s  = {in_c.green, in_c.red, in_c.blue};
        bits_s = BITS_W'(NBITS);
        ph_s   = PH_BIT_HIGH;
        cnt_s  = ticks_of(shf_s[NBITS-1] ? cfg_q[REG_ONE_HIGH] : cfg_q[REG_ZERO_HIGH]);
      end else if (in_c.operation == OP_RESET) begin
        ph_s  = PH_RST_HIGH;
        cnt_s = ticks_of(cfg_q[REG_RST_HIGH]);
      end
    end
  end

  // next state: count down the phase, then step to the next one
  always_comb begin
    logic [NBITS-1:0]  shf_n;
    logic [BITS_W-1:0] bits_n;
    shf_n      = {shf_s[NBITS-2:0], 1'b0};
    bits_n     = (bits_s == '0) ? '0 : bits_s - BITS_W'(1);
    phase_d    = ph_s;
    count_d    = cnt_s;
    shift_d    = shf_s;
    bits_d     = bits_s;
    idle_lvl_d = idle_lvl_q;
    if (ph_s != PH_IDLE) begin
      if (cnt_s > TW'(1)) begin
        count_d = cnt_s - TW'(1);
      end else begin
        count_d = '0;
        unique case (ph_s)
          PH_BIT_HIGH: begin
            phase_d = PH_BIT_LOW;
            count_d = ticks_of(shf_s[NBITS-1] ? cfg_q[REG_ONE_LOW] : cfg_q[REG_ZERO_LOW]);
          end
          PH_BIT_LOW: begin
            shift_d = shf_n;
            bits_d  = bits_n;
            if (bits_n == '0) begin
              phase_d    = PH_IDLE;
              idle_lvl_d = 1'b0;
            end else begin
              phase_d = PH_BIT_HIGH;
              count_d = ticks_of(shf_n[NBITS-1] ? cfg_q[REG_ONE_HIGH]
                                                : cfg_q[REG_ZERO_HIGH]);
            end
          end
          PH_RST_HIGH: begin
            phase_d = PH_RST_LOW;
            count_d = ticks_of(cfg_q[REG_RST_LOW]);
          end
          PH_RST_LOW: begin
            phase_d    = PH_IDLE;
            idle_lvl_d = 1'b1;
          end
          default: begin
            phase_d = PH_IDLE;
          end
        endcase
      end
    end
  end

  // outputs of this tick
  always_comb begin
    res_c.busy_res   = (ph_s != PH_IDLE);
    res_c.refused    = (phase_q != PH_IDLE) && is_cmd;
    unique case (ph_s)
      PH_IDLE:                  res_c.line_level = idle_lvl_q;
      PH_BIT_HIGH, PH_RST_HIGH: res_c.line_level = 1'b1;
      default:                  res_c.line_level = 1'b0;
    endcase
  end

  // timing registers; writes above the last index are ignored
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < NUM_REGS; i++) cfg_q[i] <= REG_RESET[i];
    end else if (cfg_we_i && (cfg_idx_i < REG_IDX_W'(NUM_REGS))) begin
      cfg_q[cfg_idx_i] <= cfg_wdata_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q    <= PH_IDLE;
      count_q    <= '0;
      shift_q    <= '0;
      bits_q     <= '0;
      idle_lvl_q <= 1'b0;
    end else if (in_fire) begin
      phase_q    <= phase_d;
      count_q    <= count_d;
      shift_q    <= shift_d;
      bits_q     <= bits_d;
      idle_lvl_q <= idle_lvl_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (in_fire) begin
      out_valid_q <= 1'b1;
    end else if (result_o.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      out_data_q <= res_c;
    end
  end

  // a busy phase never sits on an empty counter
  a_count_live: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (phase_q != PH_IDLE) |-> (count_q != '0))
    else $error("busy phase with zero counter");

  // the bit counter never exceeds one pixel
  a_bits_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    bits_q <= BITS_W'(NBITS))
    else $error("bit counter out of range");

  // a plain tick while idle gives an idle result
  a_idle_tick: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_fire && (phase_q == PH_IDLE) && (in_c.operation == OP_TICK))
      |=> (!out_data_q.busy_res && !out_data_q.refused))
    else $error("idle tick reported busy or refused");

  // a refused command is only reported during a transfer
  a_refused_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && out_data_q.refused) |-> out_data_q.busy_res)
    else $error("refused while not busy");

endmodule
